>>> hw/rtl/gscc_pkg.sv
// Shared types, codes and constants for the gas sensor calibrate-and-convert block.
// Used by the controller, the datapath, the top level and the port checker.
package gscc_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_CAL    = 2'd1,
        MODE_READ   = 2'd2,
        MODE_SAMPLE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_NONE       = 3'd0,
        STAT_WAIT       = 3'd1,
        STAT_CAL_DONE   = 3'd2,
        STAT_READ_VALID = 3'd3,
        STAT_NOT_CAL    = 3'd4,
        STAT_BUSY       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PUR_NONE = 2'd0,
        PUR_CAL  = 2'd1,
        PUR_READ = 2'd2
    } purpose_t;

    localparam logic [1:0] CFG_HEAT_WAIT = 2'd0;
    localparam logic [1:0] CFG_READ_WAIT = 2'd1;
    localparam logic [1:0] CFG_DIVIDER   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_RDIV_LD, S_RDIV, S_RDIV_END, S_CDIV_LD, S_CDIV,
        S_LOG_LD, S_LOG_NORM, S_LOG_SQ, S_LOG_FIX, S_POW_MUL, S_POW_RND,
        S_EXP_MUL, S_EXP_FIX, S_SCALE_MUL, S_SCALE_SH, S_FINISH
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ITEM, OP_RDIV_LD, OP_DIV_STEP, OP_RATIO_SET, OP_CDIV_LD,
        OP_LOG_LD, OP_LOG_NORM, OP_LOG_SQ, OP_LOG_FIX, OP_POW_MUL, OP_POW_RND,
        OP_EXP_MUL, OP_EXP_FIX, OP_SCALE_MUL, OP_SCALE_SH, OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   log_sel;   // 0: log of ratio, 1: log of baseline
    } cmd_t;

    typedef struct packed {
        logic slot_free;   // output register empty or being taken
        logic run_end;     // offered item is the last sample of a run
        logic run_cal;     // current run is a calibration run
        logic div_last;    // divider on its final step
        logic norm_done;   // log mantissa normalized
        logic iter_last;   // last squaring or exp factor step
    } stat_t;

    localparam logic [25:0] MAX26     = 26'h3FF_FFFF;
    localparam logic [23:0] MAX24     = 24'hFF_FFFF;
    localparam logic [16:0] POW_Q16   = 17'd96993;   // 1.48
    localparam logic [15:0] COEF_Q16  = 16'd57475;   // 0.877
    localparam int          DIV_STEPS = 34;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = v;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Factors 2^(2^-k), k = 1..16, in Q2.30; entry k-1 at bits [32*(k-1) +: 32].
    function automatic logic [16*32-1:0] exp2_table();
        logic [16*32-1:0] t;
        logic [63:0]      s;
        t = '0;
        s = 64'd2 << 30;
        for (int k = 0; k < 16; k++) begin
            s = isqrt64(s << 30);
            t[k*32 +: 32] = s[31:0];
        end
        return t;
    endfunction

    localparam logic [16*32-1:0] EXP2_FAC = exp2_table();

endpackage

>>> hw/rtl/gscc_ctrl.sv
// Sequencer for the gas sensor block: accepts items and steps the datapath
// through division, log, power and scaling. Depends on gscc_pkg.
module gscc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  gscc_pkg::stat_t st,
    output gscc_pkg::cmd_t  cmd
);

    gscc_pkg::ctrl_state_t state_reg, state_next;
    logic                  sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gscc_pkg::S_IDLE;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd.op      = gscc_pkg::OP_NONE;
        cmd.log_sel = sel_reg;
        s_tready    = 1'b0;
        case (state_reg)
            gscc_pkg::S_IDLE: begin
                s_tready = st.slot_free;
                if (s_tvalid && st.slot_free) begin
                    cmd.op = gscc_pkg::OP_ITEM;
                    if (st.run_end) state_next = gscc_pkg::S_RDIV_LD;
                end
            end
            gscc_pkg::S_RDIV_LD: begin
                cmd.op     = gscc_pkg::OP_RDIV_LD;
                state_next = gscc_pkg::S_RDIV;
            end
            gscc_pkg::S_RDIV: begin
                cmd.op = gscc_pkg::OP_DIV_STEP;
                if (st.div_last) state_next = gscc_pkg::S_RDIV_END;
            end
            gscc_pkg::S_RDIV_END: begin
                cmd.op   = gscc_pkg::OP_RATIO_SET;
                sel_next = 1'b0;
                state_next = st.run_cal ? gscc_pkg::S_CDIV_LD : gscc_pkg::S_LOG_LD;
            end
            gscc_pkg::S_CDIV_LD: begin
                cmd.op     = gscc_pkg::OP_CDIV_LD;
                state_next = gscc_pkg::S_CDIV;
            end
            gscc_pkg::S_CDIV: begin
                cmd.op = gscc_pkg::OP_DIV_STEP;
                if (st.div_last) state_next = gscc_pkg::S_FINISH;
            end
            gscc_pkg::S_LOG_LD: begin
                cmd.op     = gscc_pkg::OP_LOG_LD;
                state_next = gscc_pkg::S_LOG_NORM;
            end
            gscc_pkg::S_LOG_NORM: begin
                cmd.op = gscc_pkg::OP_LOG_NORM;
                if (st.norm_done) state_next = gscc_pkg::S_LOG_SQ;
            end
            gscc_pkg::S_LOG_SQ: begin
                cmd.op     = gscc_pkg::OP_LOG_SQ;
                state_next = gscc_pkg::S_LOG_FIX;
            end
            gscc_pkg::S_LOG_FIX: begin
                cmd.op = gscc_pkg::OP_LOG_FIX;
                if (!st.iter_last) begin
                    state_next = gscc_pkg::S_LOG_SQ;
                end else if (sel_reg) begin
                    state_next = gscc_pkg::S_POW_MUL;
                end else begin
                    sel_next   = 1'b1;
                    state_next = gscc_pkg::S_LOG_LD;
                end
            end
            gscc_pkg::S_POW_MUL: begin
                cmd.op     = gscc_pkg::OP_POW_MUL;
                state_next = gscc_pkg::S_POW_RND;
            end
            gscc_pkg::S_POW_RND: begin
                cmd.op     = gscc_pkg::OP_POW_RND;
                state_next = gscc_pkg::S_EXP_MUL;
            end
            gscc_pkg::S_EXP_MUL: begin
                cmd.op     = gscc_pkg::OP_EXP_MUL;
                state_next = gscc_pkg::S_EXP_FIX;
            end
            gscc_pkg::S_EXP_FIX: begin
                cmd.op     = gscc_pkg::OP_EXP_FIX;
                state_next = st.iter_last ? gscc_pkg::S_SCALE_MUL : gscc_pkg::S_EXP_MUL;
            end
            gscc_pkg::S_SCALE_MUL: begin
                cmd.op     = gscc_pkg::OP_SCALE_MUL;
                state_next = gscc_pkg::S_SCALE_SH;
            end
            gscc_pkg::S_SCALE_SH: begin
                cmd.op     = gscc_pkg::OP_SCALE_SH;
                state_next = gscc_pkg::S_FINISH;
            end
            gscc_pkg::S_FINISH: begin
                // hold the result until the output register is free
                if (st.slot_free) begin
                    cmd.op     = gscc_pkg::OP_FINISH;
                    state_next = gscc_pkg::S_IDLE;
                end
            end
            default: state_next = gscc_pkg::S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/gscc_dp.sv
// Datapath of the gas sensor block: request state, timer, sample sums, serial
// divider, log2/exp2 steps on one shared multiplier, output register. Uses gscc_pkg.
module gscc_dp #(
    parameter int SAMPLES = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_addr,
    input  logic [19:0]     cfg_wr_data,
    input  logic [1:0]      in_mode,
    input  logic [9:0]      in_sample,
    input  logic            m_tready,
    input  gscc_pkg::cmd_t  cmd,
    output gscc_pkg::stat_t st,
    output logic            out_valid,
    output logic [2:0]      out_status,
    output logic [23:0]     out_permill,
    output logic [25:0]     out_baseline,
    output logic            out_cal,
    output logic            out_rd
);

    localparam logic [16:0] FULL_SCALE = 17'(1024 * SAMPLES);
    localparam logic [6:0]  RUN_LEN    = 7'(SAMPLES);
    localparam logic [5:0]  DIV_LAST   = 6'(gscc_pkg::DIV_STEPS - 1);

    // configuration
    logic [19:0] heat_wait_reg, heat_wait_next;
    logic [15:0] read_wait_reg, read_wait_next;
    logic [15:0] divider_reg, divider_next;
    // request state
    logic        cal_reg, cal_next, rd_reg, rd_next, armed_reg, armed_next;
    logic [19:0] rem_ms_reg, rem_ms_next;
    logic [15:0] sum_reg, sum_next;
    logic [6:0]  left_reg, left_next;
    logic [1:0]  purpose_reg, purpose_next;
    logic [25:0] r0_reg, r0_next;
    // arithmetic
    logic [33:0] dvd_reg, dvd_next;
    logic [15:0] drem_reg, drem_next, dsr_reg, dsr_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic [25:0] ratio_reg, ratio_next;
    logic [31:0] m_reg, m_next;
    logic [4:0]  shift_reg, shift_next;
    logic [15:0] frac_reg, frac_next;
    logic [3:0]  iter_reg, iter_next;
    logic [21:0] la_reg, la_next, lb_reg, lb_next;
    logic        pos_reg, pos_next;
    logic [9:0]  n_reg, n_next;
    logic [15:0] f_reg, f_next;
    logic [63:0] prod_reg, prod_next;
    logic [23:0] pm_reg, pm_next;
    // output register
    logic        ov_reg, ov_next;
    logic [2:0]  os_reg, os_next;
    logic [23:0] opm_reg, opm_next;
    logic [25:0] ob_reg, ob_next;
    logic        oc_reg, oc_next, or_reg, or_next;

    logic [31:0] mul_a, mul_b;
    logic        timer_ready;
    logic        slot_free;

    assign timer_ready = armed_reg && (rem_ms_reg == 20'd0);
    assign slot_free   = !ov_reg || m_tready;

    always_comb begin
        st.slot_free = slot_free;
        st.run_end   = (in_mode == gscc_pkg::MODE_SAMPLE) && (purpose_reg != gscc_pkg::PUR_NONE)
                       && (left_reg == 7'd1);
        st.run_cal   = (purpose_reg == gscc_pkg::PUR_CAL);
        st.div_last  = (dcnt_reg == DIV_LAST);
        st.norm_done = m_reg[30];
        st.iter_last = (iter_reg == 4'd15);
    end

    // operand select for the one shared multiplier
    always_comb begin
        logic signed [22:0] ldiff;
        logic [22:0]        lmag;
        ldiff = $signed({la_reg[21], la_reg}) - $signed({lb_reg[21], lb_reg});
        lmag  = ldiff[22] ? 23'(-ldiff) : 23'(ldiff);
        mul_a = m_reg;
        mul_b = m_reg;
        case (cmd.op)
            gscc_pkg::OP_POW_MUL: begin
                mul_a = 32'(lmag);
                mul_b = 32'(gscc_pkg::POW_Q16);
            end
            gscc_pkg::OP_EXP_MUL:   mul_b = gscc_pkg::EXP2_FAC[iter_reg*32 +: 32];
            gscc_pkg::OP_SCALE_MUL: mul_b = 32'(gscc_pkg::COEF_Q16);
            default: ;
        endcase
    end

    always_comb begin
        logic [16:0]        rem_sh;
        logic [33:0]        dvd_sh;
        logic [31:0]        t;
        logic [5:0]         lexp;
        logic signed [22:0] ldiff;
        logic [23:0]        rr;
        logic [25:0]        e;
        logic [5:0]         sh;
        logic [46:0]        v;
        logic [25:0]        quo_sat;
        logic [15:0]        smp_sum;
        logic [6:0]         left_dec;

        heat_wait_next = heat_wait_reg;
        read_wait_next = read_wait_reg;
        divider_next   = divider_reg;
        cal_next = cal_reg; rd_next = rd_reg; armed_next = armed_reg;
        rem_ms_next = rem_ms_reg; sum_next = sum_reg; left_next = left_reg;
        purpose_next = purpose_reg; r0_next = r0_reg;
        dvd_next = dvd_reg; drem_next = drem_reg; dsr_next = dsr_reg; dcnt_next = dcnt_reg;
        ratio_next = ratio_reg; m_next = m_reg; shift_next = shift_reg;
        frac_next = frac_reg; iter_next = iter_reg; la_next = la_reg; lb_next = lb_reg;
        pos_next = pos_reg; n_next = n_reg; f_next = f_reg; prod_next = prod_reg;
        pm_next = pm_reg;
        ov_next = ov_reg && !m_tready;
        os_next = os_reg; opm_next = opm_reg; ob_next = ob_reg;
        oc_next = oc_reg; or_next = or_reg;

        rem_sh   = {drem_reg, dvd_reg[33]};
        dvd_sh   = {dvd_reg[32:0], 1'b0};
        t        = prod_reg[61:30];
        lexp     = 6'd14 - {1'b0, shift_reg};
        ldiff    = $signed({la_reg[21], la_reg}) - $signed({lb_reg[21], lb_reg});
        rr       = 24'((prod_reg[39:0] + 40'd32768) >> 16);
        e        = pos_reg ? 26'(-{2'b00, rr}) : {2'b00, rr};
        sh       = 6'(10'd46 - n_reg);
        v        = prod_reg[46:0] >> sh;
        quo_sat  = (|dvd_reg[33:26]) ? gscc_pkg::MAX26 : dvd_reg[25:0];
        smp_sum  = sum_reg + 16'(in_sample);
        left_dec = left_reg - 7'd1;

        if (cfg_wr_en) begin
            case (cfg_addr)
                gscc_pkg::CFG_HEAT_WAIT: heat_wait_next = cfg_wr_data;
                gscc_pkg::CFG_READ_WAIT: read_wait_next = cfg_wr_data[15:0];
                gscc_pkg::CFG_DIVIDER:   divider_next   = cfg_wr_data[15:0];
                default: ;
            endcase
        end

        case (cmd.op)
            gscc_pkg::OP_ITEM: begin
                os_next = gscc_pkg::STAT_NONE;
                case (in_mode)
                    gscc_pkg::MODE_TICK: begin
                        if (armed_reg && rem_ms_reg != 20'd0) rem_ms_next = rem_ms_reg - 20'd1;
                    end
                    gscc_pkg::MODE_CAL: begin
                        if (purpose_reg != gscc_pkg::PUR_NONE) begin
                            os_next = gscc_pkg::STAT_BUSY;
                        end else if (!cal_reg) begin
                            cal_next = 1'b1; armed_next = 1'b1; rem_ms_next = heat_wait_reg;
                            os_next = gscc_pkg::STAT_WAIT;
                        end else if (timer_ready) begin
                            armed_next = 1'b0;
                            purpose_next = gscc_pkg::PUR_CAL; left_next = RUN_LEN;
                            sum_next = 16'd0;
                            os_next = gscc_pkg::STAT_BUSY;
                        end else begin
                            if (!armed_reg) begin
                                armed_next = 1'b1; rem_ms_next = heat_wait_reg;
                            end
                            os_next = gscc_pkg::STAT_WAIT;
                        end
                    end
                    gscc_pkg::MODE_READ: begin
                        if (purpose_reg != gscc_pkg::PUR_NONE) begin
                            os_next = gscc_pkg::STAT_BUSY;
                        end else if (cal_reg) begin
                            os_next = gscc_pkg::STAT_NONE;
                        end else if (!rd_reg) begin
                            rd_next = 1'b1; armed_next = 1'b1;
                            rem_ms_next = 20'(read_wait_reg);
                            os_next = gscc_pkg::STAT_WAIT;
                        end else if (timer_ready) begin
                            armed_next = 1'b1; rem_ms_next = 20'(read_wait_reg);
                            if (r0_reg != 26'd0) begin
                                purpose_next = gscc_pkg::PUR_READ; left_next = RUN_LEN;
                                sum_next = 16'd0;
                                os_next = gscc_pkg::STAT_BUSY;
                            end else begin
                                os_next = gscc_pkg::STAT_NOT_CAL;
                            end
                        end else begin
                            if (!armed_reg) begin
                                armed_next = 1'b1; rem_ms_next = 20'(read_wait_reg);
                            end
                            os_next = gscc_pkg::STAT_WAIT;
                        end
                    end
                    default: begin
                        if (purpose_reg != gscc_pkg::PUR_NONE && left_reg != 7'd0) begin
                            sum_next  = smp_sum;
                            left_next = left_dec;
                            os_next   = gscc_pkg::STAT_BUSY;
                        end
                    end
                endcase
                // the last sample of a run reports after the arithmetic
                if (!st.run_end) begin
                    ov_next  = 1'b1;
                    opm_next = 24'd0;
                    ob_next  = r0_reg;
                    oc_next  = cal_next;
                    or_next  = rd_next;
                end
            end
            gscc_pkg::OP_RDIV_LD: begin
                dvd_next  = {1'b0, FULL_SCALE - {1'b0, sum_reg}, 16'd0};
                dsr_next  = sum_reg;
                drem_next = 16'd0;
                dcnt_next = 6'd0;
            end
            gscc_pkg::OP_CDIV_LD: begin
                dvd_next  = {ratio_reg, 8'd0};
                dsr_next  = (divider_reg == 16'd0) ? 16'd1 : divider_reg;
                drem_next = 16'd0;
                dcnt_next = 6'd0;
            end
            gscc_pkg::OP_DIV_STEP: begin
                if (rem_sh >= {1'b0, dsr_reg}) begin
                    drem_next = 16'(rem_sh - {1'b0, dsr_reg});
                    dvd_next  = {dvd_sh[33:1], 1'b1};
                end else begin
                    drem_next = rem_sh[15:0];
                    dvd_next  = dvd_sh;
                end
                dcnt_next = dcnt_reg + 6'd1;
            end
            gscc_pkg::OP_RATIO_SET: begin
                // an all-zero sum saturates the ratio
                ratio_next = (sum_reg == 16'd0) ? gscc_pkg::MAX26 : quo_sat;
            end
            gscc_pkg::OP_LOG_LD: begin
                m_next     = {6'd0, (cmd.log_sel ? r0_reg : ratio_reg)};
                shift_next = 5'd0;
                frac_next  = 16'd0;
                iter_next  = 4'd0;
            end
            gscc_pkg::OP_LOG_NORM: begin
                if (!m_reg[30]) begin
                    m_next     = {m_reg[30:0], 1'b0};
                    shift_next = shift_reg + 5'd1;
                end
            end
            gscc_pkg::OP_LOG_SQ, gscc_pkg::OP_POW_MUL, gscc_pkg::OP_EXP_MUL,
            gscc_pkg::OP_SCALE_MUL: begin
                prod_next = 64'(mul_a) * 64'(mul_b);
                if (cmd.op == gscc_pkg::OP_POW_MUL) pos_next = (ldiff > 23'sd0);
            end
            gscc_pkg::OP_LOG_FIX: begin
                if (t[31]) begin
                    m_next    = {1'b0, t[31:1]};
                    frac_next = {frac_reg[14:0], 1'b1};
                end else begin
                    m_next    = t;
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'd15) begin
                    if (cmd.log_sel) lb_next = {lexp, frac_next};
                    else             la_next = {lexp, frac_next};
                end
            end
            gscc_pkg::OP_POW_RND: begin
                n_next    = e[25:16];
                f_next    = e[15:0];
                m_next    = 32'd1 << 30;
                iter_next = 4'd0;
            end
            gscc_pkg::OP_EXP_FIX: begin
                if (f_reg[15]) m_next = t;
                f_next    = {f_reg[14:0], 1'b0};
                iter_next = iter_reg + 4'd1;
            end
            gscc_pkg::OP_SCALE_SH: begin
                if ($signed(n_reg) >= 10'sd46)       pm_next = gscc_pkg::MAX24;
                else if ($signed(n_reg) <= -10'sd18) pm_next = 24'd0;
                else if (|v[46:24])                  pm_next = gscc_pkg::MAX24;
                else                                 pm_next = v[23:0];
            end
            gscc_pkg::OP_FINISH: begin
                opm_next = 24'd0;
                if (purpose_reg == gscc_pkg::PUR_CAL) begin
                    r0_next  = quo_sat;
                    cal_next = 1'b0;
                    os_next  = gscc_pkg::STAT_CAL_DONE;
                end else if (r0_reg != 26'd0) begin
                    opm_next = pm_reg;
                    os_next  = gscc_pkg::STAT_READ_VALID;
                end else begin
                    os_next  = gscc_pkg::STAT_NOT_CAL;
                end
                purpose_next = gscc_pkg::PUR_NONE;
                ov_next = 1'b1;
                ob_next = r0_next;
                oc_next = cal_next;
                or_next = rd_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_wait_reg <= 20'd60000;
            read_wait_reg <= 16'd1000;
            divider_reg   <= 16'd15360;
            cal_reg       <= 1'b0;
            rd_reg        <= 1'b0;
            armed_reg     <= 1'b0;
            rem_ms_reg    <= 20'd0;
            sum_reg       <= 16'd0;
            left_reg      <= 7'd0;
            purpose_reg   <= gscc_pkg::PUR_NONE;
            r0_reg        <= 26'd0;
            ov_reg        <= 1'b0;
        end else begin
            heat_wait_reg <= heat_wait_next;
            read_wait_reg <= read_wait_next;
            divider_reg   <= divider_next;
            cal_reg       <= cal_next;
            rd_reg        <= rd_next;
            armed_reg     <= armed_next;
            rem_ms_reg    <= rem_ms_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            purpose_reg   <= purpose_next;
            r0_reg        <= r0_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg   <= dvd_next;   drem_reg  <= drem_next;  dsr_reg <= dsr_next;
        dcnt_reg  <= dcnt_next;  ratio_reg <= ratio_next; m_reg   <= m_next;
        shift_reg <= shift_next; frac_reg  <= frac_next;  iter_reg <= iter_next;
        la_reg    <= la_next;    lb_reg    <= lb_next;    pos_reg <= pos_next;
        n_reg     <= n_next;     f_reg     <= f_next;     prod_reg <= prod_next;
        pm_reg    <= pm_next;    os_reg    <= os_next;    opm_reg <= opm_next;
        ob_reg    <= ob_next;    oc_reg    <= oc_next;    or_reg  <= or_next;
    end

    assign out_valid    = ov_reg;
    assign out_status   = os_reg;
    assign out_permill  = opm_reg;
    assign out_baseline = ob_reg;
    assign out_cal      = oc_reg;
    assign out_rd       = or_reg;

endmodule

>>> hw/rtl/gas_sensor_calibrate_and_convert_unit.sv
// Top level of the gas sensor calibrate-and-convert block: stream ports,
// controller and datapath. Depends on gscc_pkg, gscc_ctrl and gscc_dp.
// Tick, request and mid-run sample items give their result in the cycle after
// acceptance. The last sample of a calibration run goes through two 34-step serial
// divisions; that of a reading run through one division, two log2 units (normalize
// and squaring steps on the shared multiplier), exp2 steps and scaling.
// One item at a time.
// Reset (aresetn low, synchronous): config and state to defaults, uncalibrated, no output.
module gas_sensor_calibrate_and_convert_unit #(
    parameter int SAMPLES = 16      // samples averaged per run, 1 to 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [19:0] cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] sample, [15:10] zero
    input  logic [1:0]  s_tuser,    // [1:0] mode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [23:0] permill, [49:24] baseline, [50] calibrating,
                                    // [51] reading_started, [55:52] zero
    output logic [2:0]  m_tuser     // [2:0] status
);

    gscc_pkg::cmd_t  cmd;
    gscc_pkg::stat_t st;

    logic [23:0] out_permill;
    logic [25:0] out_baseline;
    logic        out_cal;
    logic        out_rd;

    // sequence item handling and the long arithmetic of a finished run
    gscc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // hold the block state, the arithmetic units and the output register
    gscc_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .in_mode      (s_tuser),
        .in_sample    (s_tdata[9:0]),
        .m_tready     (m_tready),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (m_tvalid),
        .out_status   (m_tuser),
        .out_permill  (out_permill),
        .out_baseline (out_baseline),
        .out_cal      (out_cal),
        .out_rd       (out_rd)
    );

    // pack result fields, lowest field first
    assign m_tdata = {4'd0, out_rd, out_cal, out_baseline, out_permill};

endmodule

>>> hw/rtl/gscc_checker.sv
// Port-level checks for the gas sensor block, bound to its top level.
// Depends on gscc_pkg and gas_sensor_calibrate_and_convert_unit.
module gscc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a non-sample item always reports in the next cycle
    a_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != gscc_pkg::MODE_SAMPLE) |=> m_tvalid)
        else $error("request item gave no result");

    // concentration is zero unless the reading is valid
    a_permill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != gscc_pkg::STAT_READ_VALID) |-> (m_tdata[23:0] == 24'd0))
        else $error("permill set without valid reading");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind gas_sensor_calibrate_and_convert_unit gscc_checker u_gscc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> bench/tb_gas_sensor_calibrate_and_convert_unit.sv
// Self-checking bench for gas_sensor_calibrate_and_convert_unit: drives tick, request and
// sample items, predicts every result in-bench and compares it field by field.
// Depends on gscc_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_gas_sensor_calibrate_and_convert_unit;

    localparam int NSAMP = 16;
    localparam longint LIMIT_CYCLES = 3000000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [19:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;       // [9:0] sample, [15:10] zero
    logic [1:0]  s_tuser;       // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;       // [23:0] permill, [49:24] baseline, [50] calibrating,
                                // [51] reading_started, [55:52] zero
    logic [2:0]  m_tuser;       // [2:0] status

    gas_sensor_calibrate_and_convert_unit #(.SAMPLES(NSAMP)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] permill;
        logic [25:0] baseline;
        logic        calibrating;
        logic        reading;
    } gas_result_t;

    // Predicted sensor state and registers
    logic [19:0] heat_ms, read_ms;
    logic [15:0] divider;
    logic        cal_flag, read_flag, armed;
    logic [19:0] remain_ms;
    logic [15:0] sum_acc;
    logic [6:0]  left_cnt;
    gscc_pkg::purpose_t purpose;
    logic [25:0] r0_q16;

    gas_result_t pending_results[$];
    int          mismatch_cnt;
    longint      cycle_cnt;
    int          send_idle_pct, recv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Guard against a hung block
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("tb_gas_sensor_calibrate_and_convert_unit: errors");
            $finish;
        end
    end

    // ---------------- fixed-point math of the converter ----------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] x, res, b;
        x = v; res = 0; b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint log2_fix(input logic [63:0] v);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb = 0; frac = 0;
        for (int i = 0; i < 64; i++) if (v[i]) msb = i;
        m = v << (30 - msb);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'(msb - 16) * 65536 + longint'(frac);
    endfunction

    function automatic logic [63:0] exp2_fix(input logic [15:0] f);
        logic [63:0] m, s;
        m = 64'd1 << 30; s = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) begin
            s = int_sqrt(s << 30);
            if (f[16-k]) m = (m * s) >> 30;
        end
        return m;
    endfunction

    function automatic logic [25:0] ratio_from_sum(input logic [15:0] sum);
        logic [63:0] r;
        if (sum == 0) return gscc_pkg::MAX26;
        r = ((64'd1024 * NSAMP - 64'(sum)) << 16) / 64'(sum);
        return (r > gscc_pkg::MAX26) ? gscc_pkg::MAX26 : r[25:0];
    endfunction

    function automatic logic [23:0] concentration(input logic [25:0] ratio,
                                                  input logic [25:0] r0);
        longint      lg, p, e, n, q, sh;
        logic [63:0] a, r, prod, v;
        logic [15:0] f;
        lg = log2_fix(64'(ratio)) - log2_fix(64'(r0));
        p  = lg * 96993;
        a  = 64'((p < 0) ? -p : p);
        r  = (a + 64'd32768) / 64'd65536;
        e  = (p > 0) ? -longint'(r) : longint'(r);
        if (e >= 0) begin
            n = e / 65536;
            f = 16'(e % 65536);
        end else begin
            q = (-e + 65535) / 65536;
            n = -q;
            f = 16'(e + q * 65536);
        end
        prod = exp2_fix(f) * 64'd57475;
        sh = 46 - n;
        if (sh < 1) return gscc_pkg::MAX24;
        if (sh >= 64) return 24'd0;
        v = prod >> sh;
        return (v > gscc_pkg::MAX24) ? gscc_pkg::MAX24 : v[23:0];
    endfunction

    // ---------------- predictor ----------------
    function automatic void restart_timer(input logic [19:0] ms);
        remain_ms = ms;
        armed = 1'b1;
    endfunction

    function automatic void begin_run(input gscc_pkg::purpose_t p);
        purpose = p;
        left_cnt = 7'(NSAMP);
        sum_acc = 16'd0;
    endfunction

    function automatic gas_result_t predict_sensor(input gscc_pkg::mode_t mode,
                                                   input logic [9:0] smp);
        gas_result_t res;
        logic        ready;
        logic [25:0] ratio;
        logic [63:0] r0w;
        logic [15:0] d;
        res = '0;
        res.status = gscc_pkg::STAT_NONE;
        ready = armed && remain_ms == 20'd0;
        case (mode)
            gscc_pkg::MODE_TICK: begin
                if (armed && remain_ms > 20'd0) remain_ms = remain_ms - 20'd1;
            end
            gscc_pkg::MODE_CAL: begin
                if (purpose != gscc_pkg::PUR_NONE) res.status = gscc_pkg::STAT_BUSY;
                else if (!cal_flag) begin
                    cal_flag = 1'b1;
                    restart_timer(heat_ms);
                    res.status = gscc_pkg::STAT_WAIT;
                end else if (ready) begin
                    armed = 1'b0;
                    begin_run(gscc_pkg::PUR_CAL);
                    res.status = gscc_pkg::STAT_BUSY;
                end else begin
                    if (!armed) restart_timer(heat_ms);
                    res.status = gscc_pkg::STAT_WAIT;
                end
            end
            gscc_pkg::MODE_READ: begin
                if (purpose != gscc_pkg::PUR_NONE) res.status = gscc_pkg::STAT_BUSY;
                else if (cal_flag) res.status = gscc_pkg::STAT_NONE;
                else if (!read_flag) begin
                    read_flag = 1'b1;
                    restart_timer(read_ms);
                    res.status = gscc_pkg::STAT_WAIT;
                end else if (ready) begin
                    restart_timer(read_ms);
                    if (r0_q16 != 26'd0) begin
                        begin_run(gscc_pkg::PUR_READ);
                        res.status = gscc_pkg::STAT_BUSY;
                    end else begin
                        res.status = gscc_pkg::STAT_NOT_CAL;
                    end
                end else begin
                    if (!armed) restart_timer(read_ms);
                    res.status = gscc_pkg::STAT_WAIT;
                end
            end
            default: begin
                if (purpose != gscc_pkg::PUR_NONE && left_cnt != 7'd0) begin
                    sum_acc = sum_acc + 16'(smp);
                    left_cnt = left_cnt - 7'd1;
                    if (left_cnt != 7'd0) res.status = gscc_pkg::STAT_BUSY;
                    else begin
                        ratio = ratio_from_sum(sum_acc);
                        if (purpose == gscc_pkg::PUR_CAL) begin
                            d = (divider != 16'd0) ? divider : 16'd1;
                            r0w = (64'(ratio) * 64'd256) / 64'(d);
                            r0_q16 = (r0w > gscc_pkg::MAX26) ? gscc_pkg::MAX26 : r0w[25:0];
                            cal_flag = 1'b0;
                            res.status = gscc_pkg::STAT_CAL_DONE;
                        end else if (r0_q16 != 26'd0) begin
                            res.permill = concentration(ratio, r0_q16);
                            res.status = gscc_pkg::STAT_READ_VALID;
                        end else begin
                            res.status = gscc_pkg::STAT_NOT_CAL;
                        end
                        purpose = gscc_pkg::PUR_NONE;
                    end
                end
            end
        endcase
        res.baseline = r0_q16;
        res.calibrating = cal_flag;
        res.reading = read_flag;
        return res;
    endfunction

    // ---------------- result checker and receiver stalls ----------------
    always @(posedge aclk) begin
        gas_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.permill = m_tdata[23:0];
            got.baseline = m_tdata[49:24];
            got.calibrating = m_tdata[50];
            got.reading = m_tdata[51];
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[55:52] !== 4'd0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------- stimulus helpers ----------------
    // Send one item; hold valid until the handshake, then account its prediction.
    // Valid stays high after the handshake so back-to-back items need no gap.
    task automatic send_item(input gscc_pkg::mode_t mode, input logic [9:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {6'd0, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_sensor(mode, smp));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            gscc_pkg::CFG_HEAT_WAIT: heat_ms = val;
            gscc_pkg::CFG_READ_WAIT: read_ms = 20'(val[15:0]);
            gscc_pkg::CFG_DIVIDER:   divider = val[15:0];
            default: ;
        endcase
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(gscc_pkg::MODE_TICK, 10'($urandom));
    endtask

    task automatic send_run(input int kind);
        logic [9:0] v;
        for (int i = 0; i < NSAMP; i++) begin
            case (kind)
                0: v = 10'd0;
                1: v = 10'd1023;
                default: v = (i == 0 && $urandom_range(3) == 0) ? 10'd0 : 10'($urandom);
            endcase
            if (kind == 3) v = 10'($urandom_range(40));
            send_item(gscc_pkg::MODE_SAMPLE, v);
        end
    endtask

    // Full calibration: request, wait out the heater, request, samples.
    task automatic do_calibration(input int kind);
        send_item(gscc_pkg::MODE_CAL, 10'd0);
        send_ticks(heat_ms + $urandom_range(1));
        send_item(gscc_pkg::MODE_CAL, 10'd0);
        send_run(kind);
    endtask

    task automatic do_reading(input int kind);
        send_item(gscc_pkg::MODE_READ, 10'd0);
        send_ticks(read_ms + $urandom_range(1));
        send_item(gscc_pkg::MODE_READ, 10'd0);
        send_run(kind);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        send_item(gscc_pkg::MODE_SAMPLE, 10'd1023);      // stray sample outside a run
        send_item(gscc_pkg::MODE_TICK, 10'd0);
        write_reg(gscc_pkg::CFG_HEAT_WAIT, 20'd2);
        write_reg(gscc_pkg::CFG_READ_WAIT, 20'd1);
        write_reg(gscc_pkg::CFG_DIVIDER, 20'd0);         // zero divider acts as one
        write_reg(2'd3, 20'hFFFFF);                      // unused index, no effect
        send_item(gscc_pkg::MODE_READ, 10'd0);           // first read arms the wait
        send_ticks(2);
        send_item(gscc_pkg::MODE_READ, 10'd0);           // uncalibrated after the wait
        do_calibration(0);                               // zero sum saturates ratio
        send_item(gscc_pkg::MODE_CAL, 10'd0);
        send_item(gscc_pkg::MODE_READ, 10'd0);           // read while calibrating, ignored
        send_ticks(3);
        send_item(gscc_pkg::MODE_CAL, 10'd0);
        send_item(gscc_pkg::MODE_CAL, 10'd0);            // request during a run
        send_run(1);
    endtask

    task automatic test_extremes();
        write_reg(gscc_pkg::CFG_DIVIDER, 20'd65535);
        do_calibration(1);                     // tiny baseline may come out zero
        do_reading(2);
        write_reg(gscc_pkg::CFG_DIVIDER, 20'd1);
        do_calibration(2);
        do_reading(1);
        do_reading(0);
        // Pressure: pause until everything is back
        drain_results();
        write_reg(gscc_pkg::CFG_DIVIDER, 20'd15360);
        do_calibration(3);
        do_reading(3);
    endtask

    task automatic test_random(input int items);
        int sent, pick;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                do_calibration($urandom_range(3));
                sent += NSAMP + heat_ms + 2;
            end else if (pick < 70) begin
                do_reading($urandom_range(3) == 0 ? $urandom_range(3) : 2);
                sent += NSAMP + read_ms + 2;
            end else begin
                send_item(gscc_pkg::mode_t'($urandom_range(3)), 10'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_config_sweep();
        write_reg(gscc_pkg::CFG_HEAT_WAIT, 20'hFFFFF);
        send_item(gscc_pkg::MODE_CAL, 10'd0);            // long wait, never completes
        send_ticks(5);
        write_reg(gscc_pkg::CFG_HEAT_WAIT, 20'd0);
        write_reg(gscc_pkg::CFG_READ_WAIT, 20'hFFFF);
        write_reg(gscc_pkg::CFG_READ_WAIT, 20'd0);
        send_item(gscc_pkg::MODE_CAL, 10'd0);            // timer still armed from long wait
        write_reg(gscc_pkg::CFG_HEAT_WAIT, 20'd1);
        write_reg(gscc_pkg::CFG_DIVIDER, 20'($urandom_range(1, 65535)));
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wr_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        mismatch_cnt = 0; cycle_cnt = 0;
        send_idle_pct = 36; recv_idle_pct = 68;
        heat_ms = 20'd60000; read_ms = 20'd1000; divider = 16'd15360;
        cal_flag = 1'b0; read_flag = 1'b0; armed = 1'b0; remain_ms = 20'd0;
        sum_acc = 16'd0; left_cnt = 7'd0; purpose = gscc_pkg::PUR_NONE; r0_q16 = 26'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_extremes();
        test_random(600);
        drain_results();
        send_idle_pct = 68; recv_idle_pct = 36;
        test_config_sweep();
        test_random(600);
        drain_results();
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(gscc_pkg::CFG_READ_WAIT, 20'd2);
        write_reg(gscc_pkg::CFG_DIVIDER, 20'd256);
        test_random(600);

        drain_results();
        repeat (250) @(posedge aclk);
        if (mismatch_cnt == 0 && pending_results.size() == 0) begin
            $display("tb_gas_sensor_calibrate_and_convert_unit: clean");
        end else begin
            $display("tb_gas_sensor_calibrate_and_convert_unit: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/gscc_pkg.sv
hw/rtl/gscc_ctrl.sv
hw/rtl/gscc_dp.sv
hw/rtl/gas_sensor_calibrate_and_convert_unit.sv
hw/rtl/gscc_checker.sv
bench/tb_gas_sensor_calibrate_and_convert_unit.sv
